// ===== rtl/core/svs_pkg.sv =====
package svs_pkg;

    localparam int NUM_SEGMENTS = 10;
    localparam int MAX_SIZE     = 16;
    localparam int VALUE_WIDTH  = 32;

    localparam int SEG_W   = 4;
    localparam int SIDX_W  = $clog2(NUM_SEGMENTS);
    localparam int IDX_W   = $clog2(MAX_SIZE);
    localparam int CNT_W   = $clog2(MAX_SIZE + 1);
    localparam int DEPTH   = NUM_SEGMENTS * MAX_SIZE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int AMT_W   = 8;
    localparam int STAT_W  = 4;

    typedef enum logic [2:0] {
        OP_CREATE   = 3'd0,
        OP_APPEND   = 3'd1,
        OP_DEL_LAST = 3'd2,
        OP_DEL_VAL  = 3'd3,
        OP_RESIZE   = 3'd4,
        OP_COUNT    = 3'd5,
        OP_READ     = 3'd6,
        OP_READ_SRT = 3'd7
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 4'd0,
        ST_BAD_SEG   = 4'd1,
        ST_EXISTS    = 4'd2,
        ST_BAD_SIZE  = 4'd3,
        ST_NO_MEM    = 4'd4,
        ST_FULL      = 4'd5,
        ST_ABSENT    = 4'd6,
        ST_EMPTY     = 4'd7,
        ST_NOT_FOUND = 4'd8,
        ST_BAD_NEW   = 4'd9
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SWAP_WR,
        S_RD_RD,
        S_RD_OUT,
        S_SR_RD,
        S_SR_CMP,
        S_SR_OUT,
        S_RESP
    } state_t;

endpackage

// ===== rtl/core/segmented_value_store.sv =====
// channel | handshake           | payload
// --------+---------------------+--------------------------------
// input   | in_valid / in_stall | opcode, segment, value, amount
// output  | out_valid/out_stall | status, data, last
//
// one command at a time; delete value, read and sorted read step through the entries
// one memory read at a time, all set by the single read port of the element memory.
// rst_n clears segment info at once; the element memory needs no clearing.
// the output beat sits in a register, so a stalled output does not block
// the next command from being accepted.
module segmented_value_store
    import svs_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    opcode,
    input  logic [SEG_W-1:0]              segment,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic signed [AMT_W-1:0]       amount,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [STAT_W-1:0]             status,
    output logic signed [VALUE_WIDTH-1:0] data,
    output logic                          last
);

    // per-segment info, small enough for flip-flops
    logic             exists_reg [NUM_SEGMENTS];
    logic [CNT_W-1:0] cap_reg    [NUM_SEGMENTS];
    logic [CNT_W-1:0] cnt_reg    [NUM_SEGMENTS];

    typedef struct packed {
        logic             we;
        logic [CNT_W-1:0] cap;
        logic [CNT_W-1:0] cnt;
    } meta_wr_t;
    meta_wr_t meta_wr;

    state_t                    state_reg, state_next;
    op_t                       op_reg, op_next;
    logic [SEG_W-1:0]          seg_reg, seg_next;
    logic [VALUE_WIDTH-1:0]    val_reg, val_next;
    logic signed [AMT_W-1:0]   amt_reg, amt_next;
    logic [CNT_W-1:0]          n_reg, n_next;       // count latched at check
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [IDX_W-1:0]          hit_reg, hit_next;
    logic [CNT_W-1:0]          emit_reg, emit_next; // sorted beats emitted
    logic [VALUE_WIDTH-1:0]    prev_v_reg, prev_v_next;
    logic [IDX_W-1:0]          prev_i_reg, prev_i_next;
    logic                      have_prev_reg, have_prev_next;
    logic [VALUE_WIDTH-1:0]    best_v_reg, best_v_next;
    logic [IDX_W-1:0]          best_i_reg, best_i_next;
    logic                      have_best_reg, have_best_next;
    logic [STAT_W-1:0]         rst_st_reg, rst_st_next;
    logic [VALUE_WIDTH-1:0]    rsp_d_reg, rsp_d_next;

    logic                      ov_reg, ov_next;
    logic [STAT_W-1:0]         ost_reg, ost_next;
    logic [VALUE_WIDTH-1:0]    od_reg, od_next;
    logic                      ol_reg, ol_next;

    logic                      mem_we, mem_re;
    logic [ADDR_W-1:0]         mem_waddr, mem_raddr;
    logic [VALUE_WIDTH-1:0]    mem_wdata, mem_rdata;

    svs_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    logic [SIDX_W-1:0] sidx;
    logic              seg_ok;
    logic              cur_ex;
    logic [CNT_W-1:0]  cur_cap, cur_cnt;
    logic [IDX_W-1:0]  top_idx;
    logic              out_free;
    logic signed [AMT_W-1:0] amt_sat;
    logic signed [AMT_W+1:0] new_size;
    logic              cand_gt_prev, cand_lt_best;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [SIDX_W-1:0] s,
                                                  input logic [IDX_W-1:0] i);
        addr_of = ADDR_W'(s * MAX_SIZE + i);
    endfunction

    // lexicographic compare on (signed value, index)
    function automatic logic key_gt(input logic [VALUE_WIDTH-1:0] a,
                                    input logic [IDX_W-1:0] ai,
                                    input logic [VALUE_WIDTH-1:0] b,
                                    input logic [IDX_W-1:0] bi);
        key_gt = ($signed(a) > $signed(b)) || ((a == b) && (ai > bi));
    endfunction

    assign sidx     = SIDX_W'(seg_reg - SEG_W'(1));
    assign seg_ok   = (seg_reg != '0) && (seg_reg <= SEG_W'(NUM_SEGMENTS));
    assign cur_ex   = seg_ok ? exists_reg[sidx] : 1'b0;
    assign cur_cap  = seg_ok ? cap_reg[sidx] : '0;
    assign cur_cnt  = seg_ok ? cnt_reg[sidx] : '0;
    assign top_idx  = IDX_W'(n_reg - CNT_W'(1));
    assign out_free = !ov_reg || !out_stall;
    assign new_size = (AMT_W+2)'($signed({1'b0, cur_cap})) + (AMT_W+2)'(amt_reg);

    assign cand_gt_prev = !have_prev_reg ||
                          key_gt(mem_rdata, idx_reg, prev_v_reg, prev_i_reg);
    assign cand_lt_best = !have_best_reg ||
                          key_gt(best_v_reg, best_i_reg, mem_rdata, idx_reg);

    // saturate the size/delta field on entry
    always_comb
    begin
        if (amount < -AMT_W'(64))
        begin
            amt_sat = -AMT_W'(64);
        end
        else if (amount > AMT_W'(64))
        begin
            amt_sat = AMT_W'(64);
        end
        else
        begin
            amt_sat = amount;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        seg_next       = seg_reg;
        val_next       = val_reg;
        amt_next       = amt_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        emit_next      = emit_reg;
        prev_v_next    = prev_v_reg;
        prev_i_next    = prev_i_reg;
        have_prev_next = have_prev_reg;
        best_v_next    = best_v_reg;
        best_i_next    = best_i_reg;
        have_best_next = have_best_reg;
        rst_st_next    = rst_st_reg;
        rsp_d_next     = rsp_d_reg;
        ov_next        = ov_reg && out_stall;
        ost_next       = ost_reg;
        od_next        = od_reg;
        ol_next        = ol_reg;
        meta_wr        = '0;
        mem_we         = 1'b0;
        mem_waddr      = addr_of(sidx, '0);
        mem_wdata      = val_reg;
        mem_re         = 1'b0;
        mem_raddr      = addr_of(sidx, idx_reg);
        in_stall       = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op_t'(opcode);
                    seg_next   = segment;
                    val_next   = value;
                    amt_next   = amt_sat;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                rsp_d_next  = '0;
                rst_st_next = ST_OK;
                n_next      = cur_cnt;
                idx_next    = '0;
                state_next  = S_RESP;
                meta_wr.cap = cur_cap;
                meta_wr.cnt = cur_cnt;
                if (!seg_ok)
                begin
                    rst_st_next = ST_BAD_SEG;
                end
                else if (op_reg == OP_CREATE)
                begin
                    if (cur_ex)
                    begin
                        rst_st_next = ST_EXISTS;
                    end
                    else if (amt_reg < AMT_W'(1))
                    begin
                        rst_st_next = ST_BAD_SIZE;
                    end
                    else if (amt_reg > AMT_W'(MAX_SIZE))
                    begin
                        rst_st_next = ST_NO_MEM;
                    end
                    else
                    begin
                        meta_wr.we  = 1'b1;
                        meta_wr.cap = CNT_W'(amt_reg);
                        meta_wr.cnt = '0;
                    end
                end
                else if (!cur_ex)
                begin
                    rst_st_next = ST_ABSENT;
                end
                else
                begin
                    case (op_reg)
                        OP_APPEND:
                        begin
                            if (cur_cnt >= cur_cap)
                            begin
                                rst_st_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = addr_of(sidx, IDX_W'(cur_cnt));
                                meta_wr.we  = 1'b1;
                                meta_wr.cnt = cur_cnt + CNT_W'(1);
                            end
                        end
                        OP_DEL_LAST:
                        begin
                            if (cur_cnt == '0)
                            begin
                                rst_st_next = ST_EMPTY;
                            end
                            else
                            begin
                                meta_wr.we  = 1'b1;
                                meta_wr.cnt = cur_cnt - CNT_W'(1);
                            end
                        end
                        OP_DEL_VAL:
                        begin
                            if (cur_cnt == '0)
                            begin
                                rst_st_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        OP_RESIZE:
                        begin
                            if (new_size < (AMT_W+2)'(1))
                            begin
                                rst_st_next = ST_BAD_NEW;
                            end
                            else if (new_size > (AMT_W+2)'(MAX_SIZE))
                            begin
                                rst_st_next = ST_NO_MEM;
                            end
                            else
                            begin
                                meta_wr.we  = 1'b1;
                                meta_wr.cap = CNT_W'(new_size);
                                if (cur_cnt > CNT_W'(new_size))
                                begin
                                    meta_wr.cnt = CNT_W'(new_size);
                                end
                            end
                        end
                        OP_COUNT:
                        begin
                            if (cur_cnt == '0)
                            begin
                                rst_st_next = ST_EMPTY;
                            end
                            else
                            begin
                                rsp_d_next = VALUE_WIDTH'(cur_cnt);
                            end
                        end
                        OP_READ:
                        begin
                            if (cur_cnt != '0)
                            begin
                                state_next = S_RD_RD;
                            end
                        end
                        default:
                        begin
                            emit_next      = '0;
                            have_prev_next = 1'b0;
                            have_best_next = 1'b0;
                            if (cur_cnt != '0)
                            begin
                                state_next = S_SR_RD;
                            end
                        end
                    endcase
                end
            end
            // delete value: linear search, then move the top entry into the hole
            S_SCAN_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (mem_rdata == val_reg)
                begin
                    hit_next   = idx_reg;
                    mem_re     = 1'b1;
                    mem_raddr  = addr_of(sidx, top_idx);
                    state_next = S_SWAP_WR;
                end
                else if (idx_reg == top_idx)
                begin
                    rst_st_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_SWAP_WR:
            begin
                mem_we      = 1'b1;
                mem_waddr   = addr_of(sidx, hit_reg);
                mem_wdata   = mem_rdata;
                meta_wr.we  = 1'b1;
                meta_wr.cap = cur_cap;
                meta_wr.cnt = n_reg - CNT_W'(1);
                state_next  = S_RESP;
            end
            // stored-order read, one beat per entry
            S_RD_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    ost_next = ST_OK;
                    od_next  = mem_rdata;
                    ol_next  = (idx_reg == top_idx);
                    if (idx_reg == top_idx)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_RD_RD;
                    end
                end
            end
            // sorted read: each pass finds the smallest key above the last one sent
            S_SR_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_SR_CMP;
            end
            S_SR_CMP:
            begin
                if (cand_gt_prev && cand_lt_best)
                begin
                    best_v_next    = mem_rdata;
                    best_i_next    = idx_reg;
                    have_best_next = 1'b1;
                end
                if (idx_reg == top_idx)
                begin
                    state_next = S_SR_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_SR_RD;
                end
            end
            S_SR_OUT:
            begin
                if (out_free)
                begin
                    ov_next        = 1'b1;
                    ost_next       = ST_OK;
                    od_next        = best_v_reg;
                    ol_next        = (emit_reg == n_reg - CNT_W'(1));
                    prev_v_next    = best_v_reg;
                    prev_i_next    = best_i_reg;
                    have_prev_next = 1'b1;
                    have_best_next = 1'b0;
                    emit_next      = emit_reg + CNT_W'(1);
                    idx_next       = '0;
                    if (emit_reg == n_reg - CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SR_RD;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ost_next   = rst_st_reg;
                    od_next    = rsp_d_reg;
                    ol_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            for (int i = 0; i < NUM_SEGMENTS; i++)
            begin
                exists_reg[i] <= 1'b0;
                cap_reg[i]    <= '0;
                cnt_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (meta_wr.we)
            begin
                exists_reg[sidx] <= 1'b1;
                cap_reg[sidx]    <= meta_wr.cap;
                cnt_reg[sidx]    <= meta_wr.cnt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        seg_reg       <= seg_next;
        val_reg       <= val_next;
        amt_reg       <= amt_next;
        n_reg         <= n_next;
        idx_reg       <= idx_next;
        hit_reg       <= hit_next;
        emit_reg      <= emit_next;
        prev_v_reg    <= prev_v_next;
        prev_i_reg    <= prev_i_next;
        have_prev_reg <= have_prev_next;
        best_v_reg    <= best_v_next;
        best_i_reg    <= best_i_next;
        have_best_reg <= have_best_next;
        rst_st_reg    <= rst_st_next;
        rsp_d_reg     <= rsp_d_next;
        ost_reg       <= ost_next;
        od_reg        <= od_next;
        ol_reg        <= ol_next;
    end

    assign out_valid = ov_reg;
    assign status    = ost_reg;
    assign data      = od_reg;
    assign last      = ol_reg;

endmodule

// ===== rtl/core/svs_mem.sv =====
module svs_mem
    import svs_pkg::*;
(
    input  logic                   clk,
    input  logic                   we,
    input  logic [ADDR_W-1:0]      waddr,
    input  logic [VALUE_WIDTH-1:0] wdata,
    input  logic                   re,
    input  logic [ADDR_W-1:0]      raddr,
    output logic [VALUE_WIDTH-1:0] rdata
);

    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== tb/segmented_value_store_checker.sv =====
module segmented_value_store_checker
    import svs_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [2:0]                    opcode,
    input  logic [SEG_W-1:0]              segment,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic signed [AMT_W-1:0]       amount,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [STAT_W-1:0]             status,
    input  logic signed [VALUE_WIDTH-1:0] data,
    input  logic                          last,
    output int                            fail_count,
    output int                            pending
);

    typedef struct packed {
        logic [STAT_W-1:0]             st;
        logic signed [VALUE_WIDTH-1:0] dat;
        logic                          lst;
    } answer_t;

    answer_t answers_due[$];

    logic                          seg_live [NUM_SEGMENTS];
    int                            seg_cap  [NUM_SEGMENTS];
    int                            seg_cnt  [NUM_SEGMENTS];
    logic signed [VALUE_WIDTH-1:0] seg_vals [NUM_SEGMENTS][MAX_SIZE];

    assign pending = answers_due.size();

    function automatic answer_t mk(status_t s, logic signed [VALUE_WIDTH-1:0] d);
        answer_t a;
        a.st = s;
        a.dat = d;
        a.lst = 1'b1;
        return a;
    endfunction

    task automatic push_values(logic signed [VALUE_WIDTH-1:0] v[MAX_SIZE], int n);
        answer_t a;
        if (n == 0)
            answers_due.push_back(mk(ST_OK, '0));
        for (int i = 0; i < n; i++)
        begin
            a.st = ST_OK;
            a.dat = v[i];
            a.lst = (i == n - 1);
            answers_due.push_back(a);
        end
    endtask

    task automatic apply_command(logic [2:0] op, int seg, logic signed [VALUE_WIDTH-1:0] v,
                                 int amt);
        int s, cnt, cap, ns, j, hit;
        logic signed [VALUE_WIDTH-1:0] tmp[MAX_SIZE];
        logic signed [VALUE_WIDTH-1:0] x;
        if (amt < -64) amt = -64;
        if (amt > 64) amt = 64;
        if (seg < 1 || seg > NUM_SEGMENTS)
        begin
            answers_due.push_back(mk(ST_BAD_SEG, '0));
            return;
        end
        s = seg - 1;
        if (op == OP_CREATE)
        begin
            if (seg_live[s]) answers_due.push_back(mk(ST_EXISTS, '0));
            else if (amt < 1) answers_due.push_back(mk(ST_BAD_SIZE, '0));
            else if (amt > MAX_SIZE) answers_due.push_back(mk(ST_NO_MEM, '0));
            else
            begin
                seg_live[s] = 1'b1;
                seg_cap[s] = amt;
                seg_cnt[s] = 0;
                answers_due.push_back(mk(ST_OK, '0));
            end
            return;
        end
        if (!seg_live[s])
        begin
            answers_due.push_back(mk(ST_ABSENT, '0));
            return;
        end
        cnt = seg_cnt[s];
        cap = seg_cap[s];
        case (op)
            OP_APPEND:
                if (cnt >= cap) answers_due.push_back(mk(ST_FULL, '0));
                else
                begin
                    seg_vals[s][cnt] = v;
                    seg_cnt[s] = cnt + 1;
                    answers_due.push_back(mk(ST_OK, '0));
                end
            OP_DEL_LAST:
                if (cnt == 0) answers_due.push_back(mk(ST_EMPTY, '0));
                else
                begin
                    seg_cnt[s] = cnt - 1;
                    answers_due.push_back(mk(ST_OK, '0));
                end
            OP_DEL_VAL:
                if (cnt == 0) answers_due.push_back(mk(ST_EMPTY, '0));
                else
                begin
                    hit = -1;
                    for (int i = 0; i < cnt && hit < 0; i++)
                        if (seg_vals[s][i] == v) hit = i;
                    if (hit < 0) answers_due.push_back(mk(ST_NOT_FOUND, '0));
                    else
                    begin
                        seg_vals[s][hit] = seg_vals[s][cnt - 1];
                        seg_vals[s][cnt - 1] = v;
                        seg_cnt[s] = cnt - 1;
                        answers_due.push_back(mk(ST_OK, '0));
                    end
                end
            OP_RESIZE:
            begin
                ns = cap + amt;
                if (ns < 1) answers_due.push_back(mk(ST_BAD_NEW, '0));
                else if (ns > MAX_SIZE) answers_due.push_back(mk(ST_NO_MEM, '0));
                else
                begin
                    seg_cap[s] = ns;
                    if (cnt > ns) seg_cnt[s] = ns;
                    answers_due.push_back(mk(ST_OK, '0));
                end
            end
            OP_COUNT:
                if (cnt == 0) answers_due.push_back(mk(ST_EMPTY, '0));
                else answers_due.push_back(mk(ST_OK, VALUE_WIDTH'(cnt)));
            OP_READ:
                push_values(seg_vals[s], cnt);
            default:
            begin
                for (int i = 0; i < cnt; i++)
                begin
                    x = seg_vals[s][i];
                    j = i;
                    while (j > 0 && tmp[j - 1] > x)
                    begin
                        tmp[j] = tmp[j - 1];
                        j--;
                    end
                    tmp[j] = x;
                end
                push_values(tmp, cnt);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        int bad;
        bad = 0;
        if (!rst_n)
        begin
            fail_count <= 0;
            answers_due.delete();
            for (int i = 0; i < NUM_SEGMENTS; i++)
            begin
                seg_live[i] = 1'b0;
                seg_cap[i] = 0;
                seg_cnt[i] = 0;
            end
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("unexpected beat: status %0d data %0d", status, data);
                    bad++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d actual %0d", want.st, status);
                        bad++;
                    end
                    if (data !== want.dat)
                    begin
                        $error("data: expected %0d actual %0d", want.dat, data);
                        bad++;
                    end
                    if (last !== want.lst)
                    begin
                        $error("last: expected %0d actual %0d", want.lst, last);
                        bad++;
                    end
                end
            end
            if (bad != 0)
                fail_count <= fail_count + bad;
            if (in_valid && !in_stall)
                apply_command(opcode, int'(segment), value, int'(amount));
        end
    end

endmodule

// ===== tb/segmented_value_store_test.sv =====
module segmented_value_store_test;
    import svs_pkg::*;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [2:0]                    opcode = '0;
    logic [SEG_W-1:0]              segment = '0;
    logic signed [VALUE_WIDTH-1:0] value = '0;
    logic signed [AMT_W-1:0]       amount = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [STAT_W-1:0]             status;
    logic signed [VALUE_WIDTH-1:0] data;
    logic                          last;
    int                            fail_count;
    int                            pending;

    // long receiver hold-off requested by the stimulus
    logic                          hold_req = 1'b0;
    int                            done_holds = 0;

    // small pool of values so delete-value finds matches often
    logic signed [VALUE_WIDTH-1:0] value_pool[8];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    segmented_value_store u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .segment(segment), .value(value), .amount(amount),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .data(data), .last(last)
    );

    segmented_value_store_checker u_check (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .segment(segment), .value(value), .amount(amount),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .data(data), .last(last),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver: random stall pattern, quiet stretches, and long hold-offs on request
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // hold for a long stretch while the sender keeps offering beats
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
                done_holds <= done_holds + 1;
                @(posedge clk);
                wait (!hold_req);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(5, 60);
                end
                left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // drive one beat and hold it until accepted
    task automatic send_beat(logic [2:0] op, logic [SEG_W-1:0] seg,
                             logic signed [VALUE_WIDTH-1:0] v, logic signed [AMT_W-1:0] amt);
        in_valid <= 1'b1;
        opcode <= op;
        segment <= seg;
        value <= v;
        amount <= amt;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic idle_gap(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'sh8000_0000 ^ {31'b0, 1'($urandom_range(0, 1))};
            default: return value_pool[$urandom_range(0, 7)];
        endcase
    endfunction

    function automatic logic signed [AMT_W-1:0] pick_amount(logic [2:0] op);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return AMT_W'($urandom());
        if (op == OP_RESIZE) return AMT_W'($signed($urandom_range(0, 20)) - 10);
        return AMT_W'($urandom_range(0, 18));
    endfunction

    initial
    begin
        logic [2:0] op;
        logic [SEG_W-1:0] seg;
        int burst;
        for (int i = 0; i < 8; i++)
            value_pool[i] = $urandom();
        value_pool[0] = 32'sh7fff_ffff;
        value_pool[1] = 32'sh8000_0000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: bad segments, missing segment, create limits, full, empty,
        // delete-value swap and miss, resize both ways, reads plain and sorted
        send_beat(OP_READ, 4'd0, 0, 0);
        send_beat(OP_COUNT, 4'd11, 0, 0);
        send_beat(OP_APPEND, 4'd15, 0, 0);
        send_beat(OP_APPEND, 4'd1, 5, 0);
        send_beat(OP_CREATE, 4'd1, 0, 8'sd0);
        send_beat(OP_CREATE, 4'd1, 0, 8'sh80);
        send_beat(OP_CREATE, 4'd1, 0, 8'sd17);
        send_beat(OP_CREATE, 4'd1, 0, 8'sd127);
        send_beat(OP_CREATE, 4'd1, 0, 8'sd2);
        send_beat(OP_CREATE, 4'd1, 0, 8'sd2);
        send_beat(OP_READ, 4'd1, 0, 0);
        send_beat(OP_COUNT, 4'd1, 0, 0);
        send_beat(OP_DEL_LAST, 4'd1, 0, 0);
        send_beat(OP_DEL_VAL, 4'd1, 0, 0);
        send_beat(OP_APPEND, 4'd1, 32'sh7fff_ffff, 0);
        send_beat(OP_APPEND, 4'd1, 32'sh8000_0000, 0);
        send_beat(OP_APPEND, 4'd1, 32'sd1, 0);
        send_beat(OP_READ_SRT, 4'd1, 0, 0);
        send_beat(OP_DEL_VAL, 4'd1, 32'sd3, 0);
        send_beat(OP_DEL_VAL, 4'd1, 32'sh7fff_ffff, 0);
        send_beat(OP_RESIZE, 4'd1, 0, 8'sh80);
        send_beat(OP_RESIZE, 4'd1, 0, 8'sd127);
        send_beat(OP_CREATE, 4'd10, 0, 8'sd16);
        send_beat(OP_RESIZE, 4'd10, 0, -8'sd15);
        send_beat(OP_READ, 4'd1, 0, 0);

        // sender pause until every expected beat has come
        wait_drained();

        // long receiver hold-off while beats keep coming
        hold_req <= 1'b1;
        for (int i = 0; i < 20; i++)
            send_beat(OP_COUNT, 4'($urandom_range(1, 10)), 0, 0);
        wait (done_holds == 1);
        hold_req <= 1'b0;

        // random: mostly valid segments, appends weighted so reads get long
        for (int n = 0; n < 335; n += burst)
        begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst; k++)
            begin
                case ($urandom_range(0, 15))
                    0, 1: op = OP_CREATE;
                    2, 3, 4, 5, 6: op = OP_APPEND;
                    7: op = OP_DEL_LAST;
                    8, 9: op = OP_DEL_VAL;
                    10: op = OP_RESIZE;
                    11: op = OP_COUNT;
                    12, 13: op = OP_READ;
                    default: op = OP_READ_SRT;
                endcase
                if ($urandom_range(0, 15) == 0) op = 3'($urandom());
                seg = ($urandom_range(0, 11) == 0) ? 4'($urandom())
                                                   : 4'($urandom_range(1, 10));
                send_beat(op, seg, pick_value(), pick_amount(op));
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 30));
        end

        wait_drained();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/svs_pkg.sv
rtl/core/svs_mem.sv
rtl/core/segmented_value_store.sv
tb/segmented_value_store_checker.sv
tb/segmented_value_store_test.sv
